/* hw/rtl/grid_dda_wall_raycaster_macros.svh */
// Assertion macros for the raycaster.
`ifndef GRID_DDA_WALL_RAYCASTER_MACROS_SVH
`define GRID_DDA_WALL_RAYCASTER_MACROS_SVH

`ifndef SYNTHESIS
`define RC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("raycaster assertion failed");
`define RC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("raycaster reset assertion failed");
`else
`define RC_ASSERT(lbl, prop)
`define RC_ASSERT_RST(lbl, prop)
`endif

`endif

/* hw/rtl/rc_pkg.sv */
`timescale 1ns / 1ps

package rc_pkg;

    localparam int MAP_X     = 32;
    localparam int MAP_Y     = 32;
    localparam int TEX_WIDTH = 64;
    localparam int TEX_BITS  = $clog2(TEX_WIDTH);

    localparam int MAP_CELLS = MAP_X * MAP_Y;
    localparam int ADDR_W    = $clog2(MAP_CELLS);
    localparam int MAP_MAX   = (MAP_X > MAP_Y) ? MAP_X : MAP_Y;
    localparam int MC_W      = $clog2(MAP_MAX) + 2;

    localparam int ONE_Q16   = 65536;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_W   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_H   = 3'd7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [1:0] ST_WRITE = 2'd0;
    localparam logic [1:0] ST_HIT   = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;

    localparam int DIV_N    = 64;
    localparam int DIV_D    = 48;
    localparam int DIV_QC_W = 6;
    localparam int DIV_SH_W = $clog2(DIV_N) + 1;

    localparam logic [DIV_QC_W-1:0] QB_CAM  = 6'd27;
    localparam logic [DIV_QC_W-1:0] QB_PERP = 6'd39;
    localparam logic [DIV_QC_W-1:0] QB_LH   = 6'd27;
    localparam logic [DIV_QC_W-1:0] QB_TEX  = DIV_QC_W'(9 + TEX_BITS);

    typedef struct packed {
        logic                start;
        logic [DIV_N-1:0]    dividend;
        logic [DIV_D-1:0]    divisor;
        logic [DIV_QC_W-1:0] qbits;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        wdata;
    } t_map_req;

endpackage

/* hw/rtl/rc_in_if.sv */
`timescale 1ns / 1ps

interface rc_in_if import rc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [3:0] cell_value;
    logic [9:0] column;

    modport source (output valid, cmd, cell_x, cell_y, cell_value, column, input ready);
    modport sink (input valid, cmd, cell_x, cell_y, cell_value, column, output ready);
endinterface

/* hw/rtl/rc_out_if.sv */
`timescale 1ns / 1ps

interface rc_out_if import rc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  column_out;
    logic        hit_side;
    logic [3:0]  wall_id;
    logic [22:0] perp_dist;
    logic [15:0] line_height;
    logic [9:0]  draw_start;
    logic [9:0]  draw_end;
    logic [5:0]  tex_column;

    modport source (output valid, status, column_out, hit_side, wall_id, perp_dist,
                    line_height, draw_start, draw_end, tex_column, input ready);
    modport sink (input valid, status, column_out, hit_side, wall_id, perp_dist,
                  line_height, draw_start, draw_end, tex_column, output ready);
endinterface

/* hw/rtl/rc_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle; quotient must fit in qbits.
module rc_div import rc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_D:0]      r_rem;
    logic [DIV_N-1:0]    r_dvd;
    logic [DIV_D-1:0]    r_dsr;
    logic [DIV_N-1:0]    r_quo;
    logic [DIV_QC_W-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [DIV_D:0]      w_trial;
    logic [DIV_D:0]      w_diff;
    logic                w_ge;
    logic [DIV_SH_W-1:0] w_lsh;

    assign w_trial = {r_rem[DIV_D-1:0], r_dvd[DIV_N-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_lsh   = DIV_SH_W'(DIV_N) - {1'b0, i_req.qbits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_QC_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= (DIV_D + 1)'(i_req.dividend >> i_req.qbits);
            r_dvd <= i_req.dividend << w_lsh;
            r_dsr <= i_req.divisor;
            r_quo <= '0;
            r_cnt <= i_req.qbits;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_trial;
            r_dvd <= {r_dvd[DIV_N-2:0], 1'b0};
            r_quo <= {r_quo[DIV_N-2:0], w_ge};
            r_cnt <= r_cnt - DIV_QC_W'(1);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* hw/rtl/rc_map.sv */
`timescale 1ns / 1ps

// Map cell store, registered read, zero sweep after reset.
module rc_map import rc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_map_req   i_req,
    output logic [3:0] o_rdata,
    output logic       o_busy
);

    logic [3:0]        r_mem [MAP_CELLS];
    logic [3:0]        r_rdata;
    logic              r_clr;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(MAP_CELLS - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= 4'd0;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr;

endmodule

/* hw/rtl/grid_dda_wall_raycaster.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Item
// i_in      in   valid/ready    cmd, cell_x, cell_y, cell_value, column
// o_res     out  valid/ready    status, column_out, side, wall, distance, span, texture
// i_cfg_*   in   write enable   register index and data, no read-back
//
// One item at a time. A cast that hits uses the shared serial divider (camera x, distance,
// line height unless the distance is zero, texture column) and one map read per grid cell
// visited (up to MAP_X + MAP_Y cells).
// After reset every map cell is swept to zero with input held off.
// A finished result waits in the output register while the next item is taken.

`include "grid_dda_wall_raycaster_macros.svh"

module grid_dda_wall_raycaster import rc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rc_in_if.sink                 i_in,
    rc_out_if.source              o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CAM  = 4'd1;
    localparam logic [3:0] S_RAYM = 4'd2;
    localparam logic [3:0] S_RAYA = 4'd3;
    localparam logic [3:0] S_INIT = 4'd4;
    localparam logic [3:0] S_PQ   = 4'd5;
    localparam logic [3:0] S_STEP = 4'd6;
    localparam logic [3:0] S_LOOK = 4'd7;
    localparam logic [3:0] S_PERP = 4'd8;
    localparam logic [3:0] S_LH   = 4'd9;
    localparam logic [3:0] S_TEX  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [20:0]        r_pos_x, r_pos_y;
    logic signed [17:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [10:0]        r_scr_w, r_scr_h;
    logic [3:0]         r_state;
    logic               r_ov;

    logic signed [28:0]   r_cam;
    logic signed [46:0]   r_px, r_py;
    logic signed [31:0]   r_rdx, r_rdy;
    logic [30:0]          r_absx, r_absy;
    logic [22:0]          r_distx, r_disty;
    logic signed [MC_W-1:0] r_mx, r_my;
    logic [53:0]          r_p, r_q;
    logic [22:0]          r_cross;
    logic                 r_side;
    logic [3:0]           r_code;
    logic [51:0]          r_m1;
    logic signed [55:0]   r_m2;
    logic [46:0]          r_den;
    logic [15:0]          r_lh;

    logic [1:0]  r_w_status, r_o_status;
    logic [9:0]  r_w_col, r_o_col;
    logic        r_w_side, r_o_side;
    logic [3:0]  r_w_wall, r_o_wall;
    logic [22:0] r_w_perp, r_o_perp;
    logic [15:0] r_w_lh, r_o_lh;
    logic [9:0]  r_w_ds, r_o_ds;
    logic [9:0]  r_w_de, r_o_de;
    logic [5:0]  r_w_tex, r_o_tex;

    t_div_req   div_req;
    t_div_rsp   div_rsp;
    t_map_req   map_req;
    logic [3:0] map_rdata;
    logic       map_busy;

    logic        w_acc, w_fin_go, w_gox, w_out, w_start_out, w_mirror, w_in_map;
    logic [10:0] w_weff, w_heff;
    logic signed [MC_W-1:0] w_mx_n, w_my_n;
    logic [30:0] w_mabs;
    logic [20:0] w_mpos;
    logic signed [31:0] w_mrd;
    logic signed [57:0] w_num;
    logic [15:0] w_lh_q, w_lh_half;
    logic [10:0] w_h_half;
    logic [16:0] w_de_sum;
    logic [9:0]  w_ds, w_de;
    logic [TEX_BITS-1:0] w_tex;

    rc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rc_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rdata (map_rdata),
        .o_busy  (map_busy)
    );

    assign i_in.ready = (r_state == S_IDLE) && !map_busy;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_fin_go   = (r_state == S_FIN) && (!r_ov || o_res.ready);

    assign w_weff = (r_scr_w == '0) ? 11'd1 : r_scr_w;
    assign w_heff = (r_scr_h == '0) ? 11'd1 : r_scr_h;

    assign w_in_map = (int'(i_in.cell_x) < MAP_X) && (int'(i_in.cell_y) < MAP_Y);
    assign w_start_out = (r_rdx == '0 && r_rdy == '0)
                      || (int'(r_pos_x[20:16]) >= MAP_X) || (int'(r_pos_y[20:16]) >= MAP_Y);

    // tie steps along y
    assign w_gox  = r_p < r_q;
    assign w_mx_n = !w_gox ? r_mx : (r_rdx[31] ? r_mx - MC_W'(1) : r_mx + MC_W'(1));
    assign w_my_n = w_gox ? r_my : (r_rdy[31] ? r_my - MC_W'(1) : r_my + MC_W'(1));
    assign w_out  = w_mx_n[MC_W-1] || w_my_n[MC_W-1]
                 || (int'(w_mx_n) >= MAP_X) || (int'(w_my_n) >= MAP_Y);

    assign w_mabs = r_side ? r_absy : r_absx;
    assign w_mpos = r_side ? r_pos_x : r_pos_y;
    assign w_mrd  = r_side ? r_rdx : r_rdy;
    // offset by 256 whole cells keeps the dividend positive; fraction unchanged
    assign w_num  = $signed({6'b0, r_m1}) + 58'(r_m2) + $signed({3'b0, r_den, 8'b0});

    assign w_lh_q    = (|div_rsp.quotient[DIV_N-1:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
    assign w_lh_half = r_lh >> 1;
    assign w_h_half  = w_heff >> 1;
    assign w_ds      = ({5'b0, w_h_half} < w_lh_half) ? 10'd0
                     : 10'(w_h_half - 11'(w_lh_half));
    assign w_de_sum  = {1'b0, w_lh_half} + 17'(w_h_half);
    always_comb begin
        if (w_de_sum >= 17'(w_heff)) begin
            w_de = (w_heff - 11'd1 > 11'd1023) ? 10'd1023 : 10'(w_heff - 11'd1);
        end else begin
            w_de = (w_de_sum > 17'd1023) ? 10'd1023 : 10'(w_de_sum);
        end
    end

    assign w_tex    = div_rsp.quotient[TEX_BITS-1:0];
    assign w_mirror = (!r_side && !r_rdx[31] && r_rdx != '0) || (r_side && r_rdy[31]);

    always_comb begin
        div_req       = '0;
        map_req       = '0;
        map_req.addr  = ADDR_W'(ADDR_W'(w_mx_n) * ADDR_W'(MAP_Y) + ADDR_W'(w_my_n));
        map_req.wdata = i_in.cell_value;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_in.cmd == CMD_WRITE) begin
                    map_req.we   = w_in_map;
                    map_req.addr = ADDR_W'(ADDR_W'(i_in.cell_x) * ADDR_W'(MAP_Y)
                                 + ADDR_W'(i_in.cell_y));
                end else if (w_acc) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N'({i_in.column, 17'b0});
                    div_req.divisor  = DIV_D'(w_weff);
                    div_req.qbits    = QB_CAM;
                end
            end
            S_STEP: begin
                map_req.re = !w_out;
            end
            S_LOOK: begin
                if (map_rdata != 4'd0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N'({r_cross, 16'b0});
                    div_req.divisor  = DIV_D'(w_mabs);
                    div_req.qbits    = QB_PERP;
                end
            end
            S_PERP: begin
                if (div_rsp.done && div_rsp.quotient != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N'({w_heff, 16'b0});
                    div_req.divisor  = DIV_D'(div_rsp.quotient[38:0]);
                    div_req.qbits    = QB_LH;
                end else if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N'({w_num[55:0], {TEX_BITS{1'b0}}});
                    div_req.divisor  = DIV_D'(r_den);
                    div_req.qbits    = QB_TEX;
                end
            end
            S_LH: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N'({w_num[55:0], {TEX_BITS{1'b0}}});
                    div_req.divisor  = DIV_D'(r_den);
                    div_req.qbits    = QB_TEX;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_pos_x   <= 21'd163840;
            r_pos_y   <= 21'd163840;
            r_dir_x   <= 18'sd0;
            r_dir_y   <= -18'sd65536;
            r_plane_x <= -18'sd43254;
            r_plane_y <= 18'sd0;
            r_scr_w   <= 11'd640;
            r_scr_h   <= 11'd480;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POS_X:   r_pos_x   <= i_cfg_data;
                    CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                    CFG_DIR_X:   r_dir_x   <= i_cfg_data[17:0];
                    CFG_DIR_Y:   r_dir_y   <= i_cfg_data[17:0];
                    CFG_PLANE_X: r_plane_x <= i_cfg_data[17:0];
                    CFG_PLANE_Y: r_plane_y <= i_cfg_data[17:0];
                    CFG_SCR_W:   r_scr_w   <= i_cfg_data[10:0];
                    CFG_SCR_H:   r_scr_h   <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end

            if (w_fin_go) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= (i_in.cmd == CMD_WRITE) ? S_FIN : S_CAM;
                    end
                end
                S_CAM:  if (div_rsp.done) r_state <= S_RAYM;
                S_RAYM: r_state <= S_RAYA;
                S_RAYA: r_state <= S_INIT;
                S_INIT: r_state <= w_start_out ? S_FIN : S_PQ;
                S_PQ:   r_state <= S_STEP;
                S_STEP: r_state <= w_out ? S_FIN : S_LOOK;
                S_LOOK: r_state <= (map_rdata != 4'd0) ? S_PERP : S_STEP;
                S_PERP: begin
                    if (div_rsp.done) begin
                        r_state <= (div_rsp.quotient != '0) ? S_LH : S_TEX;
                    end
                end
                S_LH:   if (div_rsp.done) r_state <= S_TEX;
                S_TEX:  if (div_rsp.done) r_state <= S_FIN;
                S_FIN:  if (w_fin_go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_w_status <= (i_in.cmd == CMD_WRITE) ? ST_WRITE : ST_MISS;
                r_w_col    <= (i_in.cmd == CMD_WRITE) ? 10'd0 : i_in.column;
                r_w_side   <= 1'b0;
                r_w_wall   <= 4'd0;
                r_w_perp   <= 23'd0;
                r_w_lh     <= 16'd0;
                r_w_ds     <= 10'd0;
                r_w_de     <= 10'd0;
                r_w_tex    <= 6'd0;
            end
            S_CAM: begin
                r_cam <= $signed({1'b0, div_rsp.quotient[27:0]}) - 29'sd65536;
            end
            S_RAYM: begin
                r_px <= r_plane_x * r_cam;
                r_py <= r_plane_y * r_cam;
            end
            S_RAYA: begin
                r_rdx <= 32'(r_dir_x) + 32'($signed(r_px[46:16]));
                r_rdy <= 32'(r_dir_y) + 32'($signed(r_py[46:16]));
            end
            S_INIT: begin
                r_absx  <= r_rdx[31] ? 31'(-r_rdx) : r_rdx[30:0];
                r_absy  <= r_rdy[31] ? 31'(-r_rdy) : r_rdy[30:0];
                r_distx <= r_rdx[31] ? 23'(r_pos_x[15:0]) : 23'(ONE_Q16) - 23'(r_pos_x[15:0]);
                r_disty <= r_rdy[31] ? 23'(r_pos_y[15:0]) : 23'(ONE_Q16) - 23'(r_pos_y[15:0]);
                r_mx    <= MC_W'(r_pos_x[20:16]);
                r_my    <= MC_W'(r_pos_y[20:16]);
            end
            S_PQ: begin
                r_p <= r_distx * r_absy;
                r_q <= r_disty * r_absx;
            end
            S_STEP: begin
                r_mx <= w_mx_n;
                r_my <= w_my_n;
                if (w_gox) begin
                    r_cross <= r_distx;
                    r_distx <= r_distx + 23'(ONE_Q16);
                    r_p     <= r_p + {7'b0, r_absy, 16'b0};
                    r_side  <= 1'b0;
                end else begin
                    r_cross <= r_disty;
                    r_disty <= r_disty + 23'(ONE_Q16);
                    r_q     <= r_q + {7'b0, r_absx, 16'b0};
                    r_side  <= 1'b1;
                end
            end
            S_LOOK: begin
                r_code <= map_rdata;
                r_m1   <= w_mpos * w_mabs;
                r_m2   <= $signed({1'b0, r_cross}) * w_mrd;
                r_den  <= {w_mabs, 16'b0};
            end
            S_PERP: begin
                if (div_rsp.done) begin
                    r_w_perp <= (|div_rsp.quotient[DIV_N-1:23]) ? 23'h7FFFFF
                              : div_rsp.quotient[22:0];
                    r_lh     <= 16'hFFFF;
                end
            end
            S_LH: begin
                if (div_rsp.done) begin
                    r_lh <= w_lh_q;
                end
            end
            S_TEX: begin
                if (div_rsp.done) begin
                    r_w_status <= ST_HIT;
                    r_w_side   <= r_side;
                    r_w_wall   <= r_code - 4'd1;
                    r_w_lh     <= r_lh;
                    r_w_ds     <= w_ds;
                    r_w_de     <= w_de;
                    r_w_tex    <= 6'(w_mirror ? ~w_tex : w_tex);
                end
            end
            default: begin
            end
        endcase

        if (w_fin_go) begin
            r_o_status <= r_w_status;
            r_o_col    <= r_w_col;
            r_o_side   <= r_w_side;
            r_o_wall   <= r_w_wall;
            r_o_perp   <= r_w_perp;
            r_o_lh     <= r_w_lh;
            r_o_ds     <= r_w_ds;
            r_o_de     <= r_w_de;
            r_o_tex    <= r_w_tex;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.status      = r_o_status;
    assign o_res.column_out  = r_o_col;
    assign o_res.hit_side    = r_o_side;
    assign o_res.wall_id     = r_o_wall;
    assign o_res.perp_dist   = r_o_perp;
    assign o_res.line_height = r_o_lh;
    assign o_res.draw_start  = r_o_ds;
    assign o_res.draw_end    = r_o_de;
    assign o_res.tex_column  = r_o_tex;

    `RC_ASSERT(a_clear_blocks_input, map_busy |-> !i_in.ready)
    `RC_ASSERT(a_read_then_look, map_req.re |=> (r_state == S_LOOK))
    `RC_ASSERT(a_write_result_clear, (o_res.valid && o_res.status == ST_WRITE) |-> (o_res.column_out == '0 && o_res.perp_dist == '0))
    `RC_ASSERT(a_span_ordered, (o_res.valid && o_res.status == ST_HIT) |-> (o_res.draw_end >= o_res.draw_start))
    `RC_ASSERT_RST(a_reset_no_result, !i_rst_n |=> !o_res.valid)

endmodule

/* tb/sv/raycast_checker.sv */
`timescale 1ns / 1ps

module raycast_checker import rc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rc_in_if                      i_in_mon,
    rc_out_if                     i_res_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_cnt,
    output int                    o_pending
);

    typedef struct {
        logic [1:0]  status;
        logic [9:0]  column;
        logic        side;
        logic [3:0]  wall;
        logic [22:0] perp;
        logic [15:0] lh;
        logic [9:0]  ds;
        logic [9:0]  de;
        logic [5:0]  tex;
    } column_result_t;

    longint         view_x, view_y, look_x, look_y, cam_px, cam_py, scr_w, scr_h;
    logic [3:0]     grid [MAP_X][MAP_Y];
    column_result_t wanted_q [$];
    int             mismatch_cnt;

    function automatic column_result_t trace_column(logic [9:0] col);
        column_result_t r;
        longint w, h, cam, rx, ry, cx, cy, ax, ay, sx, sy, dx, dy, crossing;
        longint perp, lh, ds, de, num, den, rem, tex;
        logic [3:0] code;
        logic side, go_x;
        r = '{default: '0};
        r.column = col;
        r.status = ST_MISS;
        code = 0;
        side = 0;
        crossing = 0;
        w = (scr_w == 0) ? 1 : scr_w;
        h = (scr_h == 0) ? 1 : scr_h;
        cam = (2 * longint'(col) * ONE_Q16) / w - ONE_Q16;
        rx = look_x + ((cam_px * cam) >>> 16);
        ry = look_y + ((cam_py * cam) >>> 16);
        if (rx == 0 && ry == 0) return r;
        cx = view_x >> 16;
        cy = view_y >> 16;
        if (cx >= MAP_X || cy >= MAP_Y) return r;
        ax = rx < 0 ? -rx : rx;
        ay = ry < 0 ? -ry : ry;
        sx = rx < 0 ? -1 : 1;
        sy = ry < 0 ? -1 : 1;
        dx = rx < 0 ? view_x % ONE_Q16 : ONE_Q16 - view_x % ONE_Q16;
        dy = ry < 0 ? view_y % ONE_Q16 : ONE_Q16 - view_y % ONE_Q16;
        for (int n = 0; n < MAP_X + MAP_Y + 2; n++) begin
            if (rx == 0) go_x = 0;
            else if (ry == 0) go_x = 1;
            else go_x = (dx * ay) < (dy * ax);
            if (go_x) begin
                crossing = dx;
                dx += ONE_Q16;
                cx += sx;
                side = 0;
            end else begin
                crossing = dy;
                dy += ONE_Q16;
                cy += sy;
                side = 1;
            end
            if (cx < 0 || cx >= MAP_X || cy < 0 || cy >= MAP_Y) return r;
            code = grid[cx][cy];
            if (code != 0) break;
        end
        if (code == 0) return r;
        if (side == 0) begin
            perp = (crossing * ONE_Q16) / ax;
            num = view_y * ax + crossing * ry;
            den = ax * ONE_Q16;
        end else begin
            perp = (crossing * ONE_Q16) / ay;
            num = view_x * ay + crossing * rx;
            den = ay * ONE_Q16;
        end
        if (perp == 0) lh = 65535;
        else begin
            lh = (h * ONE_Q16) / perp;
            if (lh > 65535) lh = 65535;
        end
        ds = (lh / 2 > h / 2) ? 0 : h / 2 - lh / 2;
        de = lh / 2 + h / 2;
        if (de >= h) de = h - 1;
        if (de > 1023) de = 1023;
        rem = num % den;
        if (rem < 0) rem += den;
        tex = (rem * TEX_WIDTH) / den;
        if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) tex = TEX_WIDTH - tex - 1;
        r.status = ST_HIT;
        r.side = side;
        r.wall = code - 4'd1;
        r.perp = perp > 8388607 ? 23'h7FFFFF : 23'(perp);
        r.lh = 16'(lh);
        r.ds = 10'(ds);
        r.de = 10'(de);
        r.tex = 6'(tex);
        return r;
    endfunction

    function automatic void check_field(string nm, longint e, longint g);
        if (e != g) begin
            $error("%s mismatch: expected %0d, actual %0d", nm, e, g);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        column_result_t e;
        if (!i_rst_n) begin
            view_x = 163840;
            view_y = 163840;
            look_x = 0;
            look_y = -65536;
            cam_px = -43254;
            cam_py = 0;
            scr_w = 640;
            scr_h = 480;
            foreach (grid[x, y]) grid[x][y] = '0;
            wanted_q.delete();
            mismatch_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POS_X:   view_x = longint'(i_cfg_data);
                    CFG_POS_Y:   view_y = longint'(i_cfg_data);
                    CFG_DIR_X:   look_x = longint'($signed(i_cfg_data[17:0]));
                    CFG_DIR_Y:   look_y = longint'($signed(i_cfg_data[17:0]));
                    CFG_PLANE_X: cam_px = longint'($signed(i_cfg_data[17:0]));
                    CFG_PLANE_Y: cam_py = longint'($signed(i_cfg_data[17:0]));
                    CFG_SCR_W:   scr_w = longint'(i_cfg_data[10:0]);
                    CFG_SCR_H:   scr_h = longint'(i_cfg_data[10:0]);
                    default: ;
                endcase
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (wanted_q.size() == 0) begin
                    $error("result item with no expectation pending");
                    mismatch_cnt++;
                end else begin
                    e = wanted_q.pop_front();
                    check_field("status", e.status, i_res_mon.status);
                    check_field("column_out", e.column, i_res_mon.column_out);
                    check_field("hit_side", e.side, i_res_mon.hit_side);
                    check_field("wall_id", e.wall, i_res_mon.wall_id);
                    check_field("perp_dist", e.perp, i_res_mon.perp_dist);
                    check_field("line_height", e.lh, i_res_mon.line_height);
                    check_field("draw_start", e.ds, i_res_mon.draw_start);
                    check_field("draw_end", e.de, i_res_mon.draw_end);
                    check_field("tex_column", e.tex, i_res_mon.tex_column);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.cmd == CMD_WRITE) begin
                    if (i_in_mon.cell_x < MAP_X && i_in_mon.cell_y < MAP_Y)
                        grid[i_in_mon.cell_x][i_in_mon.cell_y] = i_in_mon.cell_value;
                    e = '{default: '0};
                    e.status = ST_WRITE;
                    wanted_q.push_back(e);
                end else begin
                    wanted_q.push_back(trace_column(i_in_mon.column));
                end
            end
        end
        o_fail_cnt <= mismatch_cnt;
        o_pending <= wanted_q.size();
    end

endmodule

/* tb/sv/tb_grid_dda_wall_raycaster.sv */
`timescale 1ns / 1ps

module tb_grid_dda_wall_raycaster;
    import rc_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_cnt;
    int                    pending;
    int                    rx_idle_pct;
    int                    tx_idle_pct;
    int                    hold_token;
    int                    hold_seen;
    int                    hold_left;
    int                    sent;

    rc_in_if  in_ch ();
    rc_out_if res_ch ();

    grid_dda_wall_raycaster dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    raycast_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_mon   (in_ch),
        .i_res_mon  (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #60ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 400;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic push_item(logic cmd, logic [4:0] x, logic [4:0] y, logic [3:0] v,
                             logic [9:0] col);
        tx_idle_pct = sent < 370 ? 18 : (sent < 740 ? 68 : 0);
        rx_idle_pct <= sent < 370 ? 68 : (sent < 740 ? 18 : 0);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.cell_x <= x;
        in_ch.cell_y <= y;
        in_ch.cell_value <= v;
        in_ch.column <= col;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic put_cell(int x, int y, int v);
        push_item(CMD_WRITE, 5'(x), 5'(y), 4'(v), 10'($urandom));
    endtask

    task automatic cast(int col);
        push_item(CMD_CAST, 5'($urandom), 5'($urandom), 4'($urandom), 10'(col));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_view(int px, int py, int dx, int dy, int cx, int cy, int w, int h);
        int vals [8];
        logic [CFG_IDX_W-1:0] idx [8];
        vals = '{px, py, dx, dy, cx, cy, w, h};
        idx = '{CFG_POS_X, CFG_POS_Y, CFG_DIR_X, CFG_DIR_Y,
                CFG_PLANE_X, CFG_PLANE_Y, CFG_SCR_W, CFG_SCR_H};
        drain();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[k];
            i_cfg_data <= CFG_DATA_W'(vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int inner_pos();
        return ($urandom_range(1, 30) << 16) | $urandom_range(65535);
    endfunction

    initial begin
        int w;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_WRITE;
        in_ch.cell_x = '0;
        in_ch.cell_y = '0;
        in_ch.cell_value = '0;
        in_ch.column = '0;
        rx_idle_pct = 0;
        hold_token = 0;
        sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: walls ahead of the reset viewer, column extremes, corner cases
        put_cell(2, 0, 15);
        put_cell(31, 31, 1);
        put_cell(1, 0, 3);
        put_cell(3, 0, 1);
        put_cell(0, 31, 0);
        cast(0);
        cast(320);
        cast(639);
        cast(640);
        cast(1023);
        set_view(163840, 163840, 0, 0, 0, 0, 640, 480);
        cast(0);
        cast(1023);
        set_view(2097151, 163840, 65536, 0, 0, 43254, 640, 480);
        cast(5);
        set_view(163840, 2097151, 0, 65536, 0, 43254, 640, 480);
        cast(5);
        set_view(163840, 163840, 0, -65536, -43254, 0, 0, 0);
        cast(0);
        cast(1);
        set_view(163840, 163840, 65536, 0, 0, 43254, 1, 1);
        cast(0);
        cast(1023);

        // perimeter walls, random codes
        for (int k = 0; k < 32; k++) begin
            put_cell(k, 0, $urandom_range(1, 15));
            put_cell(k, 31, $urandom_range(1, 15));
            put_cell(0, k, $urandom_range(1, 15));
            put_cell(31, k, $urandom_range(1, 15));
        end

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_view(inner_pos(), inner_pos(), -131072, 131071, 131071, -131072,
                            1024, 1024);
                1: set_view(inner_pos(), inner_pos(), $urandom_range(262143),
                            $urandom_range(262143), $urandom_range(262143),
                            $urandom_range(262143), 1, 1);
                2: set_view(0, inner_pos(), 131071, -131072, -131072, 131071, 2047, 2047);
                default: set_view(inner_pos(), inner_pos(), $urandom_range(262143),
                                  $urandom_range(262143), $urandom_range(262143),
                                  $urandom_range(262143), $urandom_range(1, 1024),
                                  $urandom_range(1, 1024));
            endcase
            w = (p == 1) ? 1 : (p == 0 ? 1024 : 640);
            for (int k = 0; k < 120; k++) begin
                if (p == 3 && k == 20) hold_token <= hold_token + 1;
                if (p == 5 && k == 60) drain();
                if ($urandom_range(99) < 25)
                    put_cell($urandom_range(31), $urandom_range(31),
                             $urandom_range(99) < 20 ? 0 : $urandom_range(15));
                else if ($urandom_range(99) < 85)
                    cast($urandom_range(w - 1));
                else
                    cast($urandom_range(1023));
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        for (int k = 0; k < 200000 && pending != 0; k++) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
